// File: hdl/csa_pkg.sv
// Shared constants for the contiguous segment allocator: defaults, codes.
package csa_pkg;

  localparam int unsigned MaxSegmentsDef = 32;
  localparam int unsigned AddressBitsDef = 20;

  localparam int unsigned StatusW = 3;
  localparam logic [StatusW-1:0] StOk      = 3'd0;
  localparam logic [StatusW-1:0] StNoFit   = 3'd1;
  localparam logic [StatusW-1:0] StFull    = 3'd2;
  localparam logic [StatusW-1:0] StNoOwner = 3'd3;
  localparam logic [StatusW-1:0] StBadSize = 3'd4;

  localparam logic [1:0] ModeAlloc   = 2'd0;
  localparam logic [1:0] ModeRelease = 2'd1;
  localparam logic [1:0] ModeCompact = 2'd2;

  localparam logic [1:0] FitFirst = 2'd0;
  localparam logic [1:0] FitBest  = 2'd1;
  localparam logic [1:0] FitWorst = 2'd2;

endpackage

// File: hdl/contiguous_segment_allocator_core.sv
// Contiguous segment allocator: segment table with first, best and worst fit.
//
// Input channel: in_valid_i with mode, owner, size and fit policy; the block
// drives in_stall_o high while it works on a beat. Output channel: one result
// beat per input beat on out_valid_o, held while out_stall_i is high.
// One sequencer walks the table through a single read port, one entry a cycle.
// Allocate scans every entry, then picks; a split moves the entries above
// the hole up one place and writes the remainder and the new segment. Release
// scans to the owner's segment, marks it free, then merges with a free hole
// above and a free hole below, each merge moving the entries down one place;
// a missing owner ends after a full scan. Compact scans every entry and then
// writes the top hole; a bad size or an unknown mode goes straight to finish.
// A finished result sits in the output register, so the next beat is taken
// while the receiver stalls; the block holds at the end of that next beat
// only while the earlier result is still not taken.
// Reset leaves one free hole of 2^ADDRESS_BITS bytes and zero allocated.
// A write on cfg_wdata_i (with cfg_we_i, only while idle) saturates the size
// to 1 .. 2^ADDRESS_BITS and reloads the table as one free hole.
// free_total is the managed size less allocated_total, since the segments
// always tile the memory.
module contiguous_segment_allocator_core
  import csa_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = MaxSegmentsDef,
  parameter int unsigned ADDRESS_BITS = AddressBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [ADDRESS_BITS:0]   cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              mode_i,
  input  logic [7:0]              owner_id_i,
  input  logic [ADDRESS_BITS:0]   request_size_i,
  input  logic [1:0]              fit_policy_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [StatusW-1:0]      status_o,
  output logic [ADDRESS_BITS-1:0] start_address_o,
  output logic [ADDRESS_BITS:0]   allocated_total_o,
  output logic [ADDRESS_BITS:0]   free_total_o
);

  localparam int unsigned IW = $clog2(MAX_SEGMENTS);
  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned LW = ADDRESS_BITS + 1;
  localparam logic [LW-1:0] SpanMax = LW'(1) << ADDRESS_BITS;
  localparam logic [CW-1:0] CountMax = CW'(MAX_SEGMENTS);

  typedef struct packed {
    logic [ADDRESS_BITS-1:0] start;
    logic [LW-1:0]           len;
    logic                    free;
    logic [7:0]              owner;
  } seg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_A_SCAN, S_A_PICK, S_A_GROW, S_A_SET, S_R_SCAN, S_R_MARK,
    S_R_NEXT, S_R_PREV, S_SHIFT, S_C_SCAN, S_C_END, S_FINISH
  } state_e;

  state_e state_q, ret_q;
  seg_t   seg_q [MAX_SEGMENTS];
  logic [CW-1:0] count_q, ptr_q, k_q, n_q;
  logic [IW-1:0] pick_q;
  logic          found_q;
  logic [LW-1:0] best_q, mem_q, alloc_q, cur_q, at_q, holes_q, size_q;
  logic [ADDRESS_BITS-1:0] pstart_q, addr_q;
  logic [LW-1:0] plen_q;
  logic [7:0]    owner_q;
  logic [1:0]    policy_q;
  logic [StatusW-1:0] st_q;

  logic [StatusW-1:0] status_q;
  logic [ADDRESS_BITS-1:0] out_addr_q;
  logic [LW-1:0] out_alloc_q, out_free_q;
  logic out_valid_q;

  logic [CW-1:0] rd_idx;
  seg_t          ent;
  logic          fits, take;
  logic [LW-1:0] cfg_size;
  logic [CW-1:0] pick_ext;

  assign pick_ext = CW'(pick_q);

  // Single read port: address follows the step in progress.
  always_comb begin
    unique case (state_q)
      S_A_PICK, S_R_MARK: rd_idx = pick_ext;
      S_A_GROW:           rd_idx = k_q - CW'(1);
      S_R_NEXT:           rd_idx = pick_ext + CW'(1);
      S_R_PREV:           rd_idx = pick_ext - CW'(1);
      S_SHIFT:            rd_idx = k_q + CW'(1);
      default:            rd_idx = ptr_q;
    endcase
  end
  assign ent = seg_q[rd_idx[IW-1:0]];

  // Fit compare on the entry under the scan pointer.
  assign fits = ent.free && (ent.len >= size_q);
  always_comb begin
    unique case (policy_q)
      FitFirst: take = fits && !found_q;
      FitBest:  take = fits && (!found_q || ent.len < best_q);
      FitWorst: take = fits && (!found_q || ent.len > best_q);
      default:  take = 1'b0;
    endcase
  end

  always_comb begin
    if (cfg_wdata_i == '0) begin
      cfg_size = LW'(1);
    end else if (cfg_wdata_i > SpanMax) begin
      cfg_size = SpanMax;
    end else begin
      cfg_size = cfg_wdata_i;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_FINISH;
      count_q     <= CW'(1);
      mem_q       <= SpanMax;
      alloc_q     <= '0;
      out_valid_q <= 1'b0;
      seg_q[0]    <= '{start: '0, len: SpanMax, free: 1'b1, owner: '0};
    end else begin
      // Drop the result once the receiver takes it; the finish step reloads it.
      if (out_valid_q && !out_stall_i && (state_q != S_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cfg_we_i) begin
            mem_q    <= cfg_size;
            alloc_q  <= '0;
            count_q  <= CW'(1);
            seg_q[0] <= '{start: '0, len: cfg_size, free: 1'b1, owner: '0};
          end else if (in_valid_i) begin
            size_q   <= request_size_i;
            owner_q  <= owner_id_i;
            policy_q <= fit_policy_i;
            st_q     <= ((mode_i == ModeAlloc) && (request_size_i == '0)) ? StBadSize : StOk;
            addr_q   <= '0;
            ptr_q    <= '0;
            found_q  <= 1'b0;
            n_q      <= '0;
            at_q     <= '0;
            holes_q  <= '0;
            unique case (mode_i)
              ModeAlloc: begin
                if (request_size_i == '0) begin
                  state_q <= S_FINISH;
                end else begin
                  state_q <= S_A_SCAN;
                end
              end
              ModeRelease: state_q <= S_R_SCAN;
              ModeCompact: state_q <= S_C_SCAN;
              default:     state_q <= S_FINISH;
            endcase
          end
        end

        S_A_SCAN: begin
          if (ptr_q == count_q) begin
            state_q <= S_A_PICK;
          end else begin
            if (take) begin
              found_q <= 1'b1;
              pick_q  <= ptr_q[IW-1:0];
              best_q  <= ent.len;
            end
            ptr_q <= ptr_q + CW'(1);
          end
        end

        S_A_PICK: begin
          pstart_q <= ent.start;
          plen_q   <= ent.len;
          k_q      <= count_q;
          if (!found_q) begin
            st_q    <= StNoFit;
            state_q <= S_FINISH;
          end else if (ent.len > size_q) begin
            if (count_q == CountMax) begin
              st_q    <= StFull;
              state_q <= S_FINISH;
            end else begin
              state_q <= S_A_GROW;
            end
          end else begin
            seg_q[pick_q] <= '{start: ent.start, len: size_q, free: 1'b0, owner: owner_q};
            addr_q        <= ent.start;
            alloc_q       <= alloc_q + size_q;
            state_q       <= S_FINISH;
          end
        end

        S_A_GROW: begin
          // Move entries up one place to open the slot after the hole.
          if (k_q > pick_ext + CW'(1)) begin
            seg_q[k_q[IW-1:0]] <= ent;
            k_q                <= k_q - CW'(1);
          end else begin
            seg_q[k_q[IW-1:0]] <= '{start: pstart_q + size_q[ADDRESS_BITS-1:0],
                                    len: plen_q - size_q, free: 1'b1, owner: '0};
            state_q <= S_A_SET;
          end
        end

        S_A_SET: begin
          seg_q[pick_q] <= '{start: pstart_q, len: size_q, free: 1'b0, owner: owner_q};
          count_q       <= count_q + CW'(1);
          addr_q        <= pstart_q;
          alloc_q       <= alloc_q + size_q;
          state_q       <= S_FINISH;
        end

        S_R_SCAN: begin
          if (ptr_q == count_q) begin
            st_q    <= StNoOwner;
            state_q <= S_FINISH;
          end else if (!ent.free && ent.owner == owner_q) begin
            pick_q  <= ptr_q[IW-1:0];
            state_q <= S_R_MARK;
          end else begin
            ptr_q <= ptr_q + CW'(1);
          end
        end

        S_R_MARK: begin
          seg_q[pick_q] <= '{start: ent.start, len: ent.len, free: 1'b1, owner: '0};
          addr_q        <= ent.start;
          alloc_q       <= alloc_q - ent.len;
          cur_q         <= ent.len;
          state_q       <= S_R_NEXT;
        end

        S_R_NEXT: begin
          // Merge with a free hole above.
          if ((pick_ext + CW'(1) < count_q) && ent.free) begin
            seg_q[pick_q].len <= cur_q + ent.len;
            cur_q             <= cur_q + ent.len;
            k_q               <= pick_ext + CW'(1);
            ret_q             <= S_R_PREV;
            state_q           <= S_SHIFT;
          end else begin
            state_q <= S_R_PREV;
          end
        end

        S_R_PREV: begin
          // Merge into a free hole below.
          if ((pick_q != '0) && ent.free) begin
            seg_q[rd_idx[IW-1:0]].len <= ent.len + cur_q;
            k_q     <= pick_ext;
            ret_q   <= S_FINISH;
            state_q <= S_SHIFT;
          end else begin
            state_q <= S_FINISH;
          end
        end

        S_SHIFT: begin
          // Close the gap left at k by moving entries down one place.
          if (k_q + CW'(1) < count_q) begin
            seg_q[k_q[IW-1:0]] <= ent;
            k_q                <= k_q + CW'(1);
          end else begin
            count_q <= count_q - CW'(1);
            state_q <= ret_q;
          end
        end

        S_C_SCAN: begin
          if (ptr_q == count_q) begin
            state_q <= S_C_END;
          end else begin
            if (ent.free) begin
              holes_q <= holes_q + ent.len;
            end else begin
              seg_q[n_q[IW-1:0]] <= '{start: at_q[ADDRESS_BITS-1:0], len: ent.len,
                                      free: 1'b0, owner: ent.owner};
              at_q <= at_q + ent.len;
              n_q  <= n_q + CW'(1);
            end
            ptr_q <= ptr_q + CW'(1);
          end
        end

        S_C_END: begin
          // Leave the gathered free bytes as one hole at the top.
          if (holes_q != '0) begin
            seg_q[n_q[IW-1:0]] <= '{start: at_q[ADDRESS_BITS-1:0], len: holes_q,
                                    free: 1'b1, owner: '0};
            count_q <= n_q + CW'(1);
          end else begin
            count_q <= n_q;
          end
          state_q <= S_FINISH;
        end

        S_FINISH: begin
          // Hold here only while an older result still waits.
          if (!out_valid_q || !out_stall_i) begin
            status_q    <= st_q;
            out_addr_q  <= (st_q == StOk) ? addr_q : '0;
            out_alloc_q <= alloc_q;
            out_free_q  <= mem_q - alloc_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign start_address_o   = out_addr_q;
  assign allocated_total_o = out_alloc_q;
  assign free_total_o      = out_free_q;

endmodule
